// ----- rtl/mls_pkg.sv -----
// ----------------------------------------------------------------------------
// mls_pkg
// Shared widths, limits and item codes of the mesh Laplacian smoother.
// ----------------------------------------------------------------------------
package mls_pkg;

    localparam int MAX_POINTS     = 1024;
    localparam int MAX_NEIGHBOURS = 16;
    localparam int PT_W           = 10;
    localparam int SLOT_W         = 4;
    localparam int DEG_W          = 5;
    localparam int COORD_W        = 32;
    localparam int SUM_W          = 36;
    localparam int RELAX_BITS     = 16;
    localparam int RELAX_W        = 17;
    localparam int ITER_W         = 16;
    localparam int NPT_W          = 11;
    localparam int IN_DATA_W      = 128;
    localparam int OUT_DATA_W     = 112;

    localparam logic [RELAX_W-1:0] RELAX_ONE  = 17'h10000;
    localparam logic [DEG_W-1:0]   DEG_MAX    = 5'd16;
    localparam logic [NPT_W-1:0]   POINTS_MAX = 11'd1024;

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_LINK = 2'd1;
    localparam logic [1:0] MODE_RUN  = 2'd2;
    localparam logic [1:0] MODE_READ = 2'd3;

    localparam logic [1:0] REG_ITER   = 2'd0;
    localparam logic [1:0] REG_RELAX  = 2'd1;
    localparam logic [1:0] REG_POINTS = 2'd2;

endpackage

// ----- rtl/mesh_laplacian_smoother.sv -----
// ----------------------------------------------------------------------------
// mesh_laplacian_smoother
// Relaxed Jacobi Laplacian smoothing of mesh points held in on-chip memories.
//
// Input stream: tuser carries the mode (load point, load link, run, read),
// tdata the point fields. Loads give no result. A read gives one result,
// read into a register and moved to the output register once that is free.
// A run sweeps the first points_in_use points iteration_count times and then
// gives one result with run_done set. Per sweep a point passes P0, P1, L and
// A for each neighbour (fetched one at a time through the single coordinate
// read port), a serial divider for the mean, then MUL and ADD per coordinate
// and WN (a point without neighbours goes from P1 straight to WN); a commit
// pass of C0 and C1 per point follows. The input is held off while a run or
// read is in progress. Results sit in an output register; a stalled receiver
// holds it, and load items are still taken meanwhile.
// Configuration writes are taken at any cycle and are meant for idle time.
// Reset sets the state and configuration registers to their defaults; the
// point memories are not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module mesh_laplacian_smoother
    import mls_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // point_index, pos_x, pos_y, pos_z, held_fixed, neighbour_total,
    // neighbour_slot, neighbour_index
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // mode
    input  logic [1:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // out_index, out_x, out_y, out_z
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // run_done
    output logic                  m_axis_tuser,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [RELAX_W-1:0]    i_cfg_data
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RDD  = 4'd1;
    localparam logic [3:0] S_P0   = 4'd2;
    localparam logic [3:0] S_P1   = 4'd3;
    localparam logic [3:0] S_L    = 4'd4;
    localparam logic [3:0] S_A    = 4'd5;
    localparam logic [3:0] S_DIV  = 4'd6;
    localparam logic [3:0] S_MUL  = 4'd7;
    localparam logic [3:0] S_ADD  = 4'd8;
    localparam logic [3:0] S_WN   = 4'd9;
    localparam logic [3:0] S_C0   = 4'd10;
    localparam logic [3:0] S_C1   = 4'd11;
    localparam logic [3:0] S_DONE = 4'd12;

    localparam int C3 = 3 * COORD_W;

    logic [C3-1:0]        coord_mem [MAX_POINTS];
    logic [C3-1:0]        next_mem  [MAX_POINTS];
    logic [DEG_W:0]       meta_mem  [MAX_POINTS];
    logic [PT_W-1:0]      link_mem  [MAX_POINTS*MAX_NEIGHBOURS];

    logic [C3-1:0]        coord_q, next_q;
    logic [DEG_W:0]       meta_q;
    logic [PT_W-1:0]      link_q;

    logic [3:0]           r_state;
    logic [ITER_W-1:0]    r_iter_cfg, r_iter;
    logic [RELAX_W-1:0]   r_relax;
    logic [NPT_W-1:0]     r_npts, r_pt;
    logic [DEG_W-1:0]     r_deg, r_cnt;
    logic [5:0]           r_dcnt;
    logic [1:0]           r_c;
    logic                 r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                 r_out_done;
    logic [PT_W-1:0]      r_rd_idx;

    logic signed [SUM_W-1:0]   r_sum [3];
    logic [SUM_W-1:0]          r_div [3];
    logic [DEG_W-1:0]          r_rem [3];
    logic                      r_neg [3];
    logic [COORD_W-1:0]        r_old [3];
    logic [COORD_W-1:0]        r_new [3];
    logic signed [49:0]        r_p1, r_p2;

    logic in_fire, out_free, out_load;
    logic [1:0]         in_mode;
    logic [PT_W-1:0]    in_idx;
    logic [DEG_W-1:0]   in_deg, in_deg_sat;

    logic               coord_re, meta_re, next_re, link_re;
    logic [PT_W-1:0]    coord_ra;
    logic [PT_W+SLOT_W-1:0] link_ra;
    logic [DEG_W-1:0]   link_j;

    logic signed [32:0] mean_sel;
    logic [COORD_W-1:0] old_sel;
    logic signed [50:0] wsum;

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign out_load      = ((r_state == S_RDD) || (r_state == S_DONE)) && out_free;
    assign in_mode       = s_axis_tuser;
    assign in_idx        = s_axis_tdata[9:0];
    assign in_deg        = s_axis_tdata[111:107];
    assign in_deg_sat    = (in_deg > DEG_MAX) ? DEG_MAX : in_deg;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_done;

    always_comb begin
        coord_re = 1'b0;
        meta_re  = 1'b0;
        next_re  = 1'b0;
        link_re  = 1'b0;
        coord_ra = r_pt[PT_W-1:0];
        link_j   = r_cnt;
        case (r_state)
            S_IDLE: begin
                coord_re = in_fire && (in_mode == MODE_READ);
                coord_ra = in_idx;
            end
            S_P0: begin
                coord_re = 1'b1;
                meta_re  = 1'b1;
                link_re  = 1'b1;
                link_j   = '0;
            end
            S_L: begin
                coord_re = 1'b1;
                coord_ra = link_q;
                link_re  = 1'b1;
                link_j   = r_cnt + 5'd1;
            end
            S_C0: begin
                meta_re = 1'b1;
                next_re = 1'b1;
            end
            default: begin
            end
        endcase
    end
    assign link_ra = {r_pt[PT_W-1:0], link_j[SLOT_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (coord_re) begin
            coord_q <= coord_mem[coord_ra];
        end
        if (meta_re) begin
            meta_q <= meta_mem[r_pt[PT_W-1:0]];
        end
        if (next_re) begin
            next_q <= next_mem[r_pt[PT_W-1:0]];
        end
        if (link_re) begin
            link_q <= link_mem[link_ra];
        end
        if (in_fire && (in_mode == MODE_LOAD)) begin
            coord_mem[in_idx] <= s_axis_tdata[105:10];
            meta_mem[in_idx]  <= {s_axis_tdata[106], in_deg_sat};
        end else if ((r_state == S_C1) && !meta_q[DEG_W]) begin
            coord_mem[r_pt[PT_W-1:0]] <= next_q;
        end
        if (in_fire && (in_mode == MODE_LINK)) begin
            link_mem[{in_idx, s_axis_tdata[115:112]}] <= s_axis_tdata[125:116];
        end
        if (r_state == S_WN) begin
            next_mem[r_pt[PT_W-1:0]] <= {r_new[2], r_new[1], r_new[0]};
        end
    end

    always_comb begin
        case (r_c)
            2'd1: begin
                mean_sel = r_neg[1] ? -$signed({1'b0, r_div[1][31:0]})
                                    : $signed({1'b0, r_div[1][31:0]});
                old_sel  = r_old[1];
            end
            2'd2: begin
                mean_sel = r_neg[2] ? -$signed({1'b0, r_div[2][31:0]})
                                    : $signed({1'b0, r_div[2][31:0]});
                old_sel  = r_old[2];
            end
            default: begin
                mean_sel = r_neg[0] ? -$signed({1'b0, r_div[0][31:0]})
                                    : $signed({1'b0, r_div[0][31:0]});
                old_sel  = r_old[0];
            end
        endcase
    end
    assign wsum = {r_p1[49], r_p1} + {r_p2[49], r_p2};

    always_ff @(posedge i_clk) begin
        logic [DEG_W:0] t;
        case (r_state)
            S_P1: begin
                for (int k = 0; k < 3; k++) begin
                    r_old[k] <= coord_q[k*COORD_W +: COORD_W];
                    r_new[k] <= coord_q[k*COORD_W +: COORD_W];
                    r_sum[k] <= '0;
                end
            end
            S_A: begin
                for (int k = 0; k < 3; k++) begin
                    r_sum[k] <= r_sum[k] + SUM_W'($signed(coord_q[k*COORD_W +: COORD_W]));
                end
            end
            S_DIV: begin
                for (int k = 0; k < 3; k++) begin
                    if (r_dcnt == '0) begin
                        r_neg[k] <= r_sum[k][SUM_W-1];
                        r_div[k] <= r_sum[k][SUM_W-1] ? SUM_W'(-r_sum[k])
                                                       : SUM_W'(r_sum[k]);
                        r_rem[k] <= '0;
                    end else begin
                        t = {r_rem[k], r_div[k][SUM_W-1]};
                        if (t >= {1'b0, r_deg}) begin
                            r_rem[k] <= DEG_W'(t - {1'b0, r_deg});
                            r_div[k] <= {r_div[k][SUM_W-2:0], 1'b1};
                        end else begin
                            r_rem[k] <= t[DEG_W-1:0];
                            r_div[k] <= {r_div[k][SUM_W-2:0], 1'b0};
                        end
                    end
                end
            end
            S_MUL: begin
                r_p1 <= $signed({1'b0, r_relax}) * mean_sel;
                r_p2 <= $signed({1'b0, RELAX_ONE - r_relax}) * $signed(old_sel);
            end
            S_ADD: begin
                r_new[r_c] <= wsum[RELAX_BITS +: COORD_W];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_iter_cfg  <= 16'd1;
            r_relax     <= RELAX_ONE;
            r_npts      <= '0;
            r_out_valid <= 1'b0;
            r_pt        <= '0;
            r_iter      <= '0;
            r_cnt       <= '0;
            r_deg       <= '0;
            r_dcnt      <= '0;
            r_c         <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_ITER:   r_iter_cfg <= i_cfg_data[ITER_W-1:0];
                    REG_RELAX:  r_relax <= (i_cfg_data > RELAX_ONE) ? RELAX_ONE : i_cfg_data;
                    REG_POINTS: r_npts <= (i_cfg_data[NPT_W-1:0] > POINTS_MAX)
                                          ? POINTS_MAX : i_cfg_data[NPT_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_fire && (in_mode == MODE_READ)) begin
                        r_rd_idx <= in_idx;
                        r_state <= S_RDD;
                    end else if (in_fire && (in_mode == MODE_RUN)) begin
                        r_pt   <= '0;
                        r_iter <= '0;
                        r_state <= ((r_iter_cfg == '0) || (r_npts == '0)) ? S_DONE : S_P0;
                    end
                end
                S_RDD: begin
                    if (out_free) begin
                        r_out_done  <= 1'b0;
                        r_out_data  <= {{(OUT_DATA_W-PT_W-C3){1'b0}}, coord_q, r_rd_idx};
                        r_state <= S_IDLE;
                    end
                end
                S_P0: begin
                    r_state <= S_P1;
                end
                S_P1: begin
                    r_deg <= meta_q[DEG_W-1:0];
                    r_cnt <= '0;
                    r_c   <= '0;
                    r_dcnt <= '0;
                    r_state <= (meta_q[DEG_W-1:0] == '0) ? S_WN : S_L;
                end
                S_L: begin
                    r_state <= S_A;
                end
                S_A: begin
                    r_cnt <= r_cnt + 5'd1;
                    r_state <= (r_cnt + 5'd1 < r_deg) ? S_L : S_DIV;
                end
                S_DIV: begin
                    r_dcnt <= r_dcnt + 6'd1;
                    if (r_dcnt == 6'(SUM_W)) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_c <= r_c + 2'd1;
                    r_state <= (r_c == 2'd2) ? S_WN : S_MUL;
                end
                S_WN: begin
                    if (r_pt + 11'd1 < r_npts) begin
                        r_pt <= r_pt + 11'd1;
                        r_state <= S_P0;
                    end else begin
                        r_pt <= '0;
                        r_state <= S_C0;
                    end
                end
                S_C0: begin
                    r_state <= S_C1;
                end
                S_C1: begin
                    if (r_pt + 11'd1 < r_npts) begin
                        r_pt <= r_pt + 11'd1;
                        r_state <= S_C0;
                    end else begin
                        r_pt <= '0;
                        r_iter <= r_iter + 16'd1;
                        r_state <= ({1'b0, r_iter} + 17'd1 < {1'b0, r_iter_cfg}) ? S_P0 : S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_done  <= 1'b1;
                        r_out_data  <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_axis_tready |=> r_out_valid)
        else $error("result dropped while stalled");
    a_busy_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready)
        else $error("input taken while busy");
    a_nb_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_A) |-> (r_cnt < r_deg) && (r_deg <= DEG_MAX))
        else $error("neighbour count past degree");
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_dcnt <= 6'(SUM_W)))
        else $error("divider overran");

endmodule
